[rtl/ntpcal_pkg.sv]
package ntpcal_pkg;

    // Request beat: summary of one NTP reply
    typedef struct packed {
        logic [15:0] source_port;
        logic [15:0] packet_length;
        logic [7:0]  first_byte;
        logic [7:0]  stratum;
        logic [31:0] transmit_seconds;
    } t_req;

    // Result beat: local calendar time
    typedef struct packed {
        logic        time_valid;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        summer_time;
    } t_res;

    typedef logic signed [16:0] t_zone;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
    } t_date;

    localparam logic [15:0] PORT_NTP       = 16'd123;
    localparam logic [15:0] LEN_MIN        = 16'd48;
    localparam logic [2:0]  MODE_SERVER    = 3'd4;
    localparam logic [7:0]  STRATUM_MIN    = 8'd1;
    localparam logic [7:0]  STRATUM_MAX    = 8'd4;
    localparam logic [31:0] UNIX_DELTA     = 32'd2208988800;
    localparam logic [32:0] SEC_PER_DAY    = 33'd86400;
    localparam logic [32:0] SEC_PER_HOUR   = 33'd3600;
    localparam t_zone       ZONE_RESET     = 17'sd3600;
    localparam logic [3:0]  MONTH_MAR      = 4'd3;
    localparam logic [3:0]  MONTH_OCT      = 4'd10;
    localparam logic [4:0]  DAYS_LONG_MON  = 5'd31;
    localparam logic [2:0]  DAYS_PER_WEEK  = 3'd7;

    // First day of each month, counted from March 1 (index 0 is March)
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        unique case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/ntpcal_stream_if.sv]
interface ntpcal_stream_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/ntpcal_cdiv.sv]
module ntpcal_cdiv #(
    parameter int unsigned XW = 33,
    parameter int unsigned D  = 675,
    parameter int unsigned SH = 7,
    parameter int unsigned QW = 16,
    parameter int unsigned RW = $clog2(D * (2 ** SH)),
    parameter type t_pay = logic
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [XW-1:0] i_x,
    input  t_pay          i_pay,
    output logic          o_vld,
    output logic [QW-1:0] o_q,
    output logic [RW-1:0] o_r,
    output t_pay          o_pay
);
    // Divide by (D << SH): shift out the power of two, then multiply by a
    // rounded-up reciprocal of the odd part, exact for every XW-bit input.
    localparam int unsigned XSW = XW - SH;
    localparam int unsigned K   = XSW + $clog2(D);
    localparam int unsigned MW  = XSW + 1;
    localparam int unsigned PW  = XSW + MW;
    localparam logic [63:0] M   = ((64'd1 << K) + 64'(D) - 64'd1) / 64'(D);
    localparam logic [XW-1:0] DF = XW'(64'(D) << SH);

    logic [PW-1:0] w_prod;
    logic [QW-1:0] n_q1;
    logic [XW-1:0] n_rem;

    logic          r_vld1, r_vld2;
    logic [QW-1:0] r_q1, r_q2;
    logic [XW-1:0] r_x1;
    logic [RW-1:0] r_r2;
    t_pay          r_pay1, r_pay2;

    assign w_prod = PW'(i_x[XW-1:SH]) * PW'(M[MW-1:0]);
    assign n_q1   = QW'(w_prod >> K);
    assign n_rem  = r_x1 - XW'(r_q1) * DF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1   <= n_q1;
            r_x1   <= i_x;
            r_pay1 <= i_pay;
            r_q2   <= r_q1;
            r_r2   <= RW'(n_rem);
            r_pay2 <= r_pay1;
        end
    end

    assign o_vld = r_vld2;
    assign o_q   = r_q2;
    assign o_r   = r_r2;
    assign o_pay = r_pay2;
endmodule

[rtl/ntpcal_civil.sv]
module ntpcal_civil #(
    parameter type t_pay = logic
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [15:0]       i_days,
    input  t_pay              i_pay,
    output logic              o_vld,
    output ntpcal_pkg::t_date o_date,
    output t_pay              o_pay
);
    import ntpcal_pkg::*;

    // i_days counts from 1969-12-31 (day one is 1970-01-01). Work in days
    // since 1968-03-01 so four-year cycles start on a leap March; skip the
    // missing 2100-02-29 by shifting later days up by one.
    localparam logic [15:0] BASE = 16'd670;
    localparam logic [15:0] GAP  = 16'd47542;

    typedef struct packed {
        t_pay pay;
        logic fix;
    } t_cyc;

    logic         r_vld1, r_fix1;
    logic [15:0]  r_fake1;
    t_pay         r_pay1;
    logic         n_fix1;

    logic         w_c_vld;
    logic [5:0]   w_c;
    logic [10:0]  w_r;
    t_cyc         w_c_pay;

    logic [1:0]   n_yoe2;
    logic [8:0]   n_doy2;
    logic [11:0]  n_year2;
    logic [10:0]  n_wsum2;
    logic         r_vld2;
    logic [8:0]   r_doy2;
    logic [11:0]  r_year2;
    logic [10:0]  r_wsum2;
    t_pay         r_pay2;

    logic [3:0]   n_mp3;
    logic [4:0]   n_dd3;
    logic [22:0]  w_prod3;
    logic         r_vld3;
    logic [3:0]   r_mp3;
    logic [4:0]   r_dd3;
    logic [7:0]   r_q3;
    logic [10:0]  r_wsum3;
    logic [11:0]  r_year3;
    t_pay         r_pay3;

    t_date        n_date4;
    logic         r_vld4;
    t_date        r_date4;
    t_pay         r_pay4;

    assign n_fix1 = (i_days >= GAP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fix1  <= n_fix1;
            r_fake1 <= i_days + BASE + 16'(n_fix1);
            r_pay1  <= i_pay;
        end
    end

    ntpcal_cdiv #(
        .XW(16), .D(1461), .SH(0), .QW(6), .t_pay(t_cyc)
    ) u_cyc (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (i_en),
        .i_vld  (r_vld1),
        .i_x    (r_fake1),
        .i_pay  ('{pay: r_pay1, fix: r_fix1}),
        .o_vld  (w_c_vld),
        .o_q    (w_c),
        .o_r    (w_r),
        .o_pay  (w_c_pay)
    );

    // Year within the cycle and day of that March-based year
    always_comb begin
        priority if (w_r >= 11'd1095) n_yoe2 = 2'd3;
        else if (w_r >= 11'd730)      n_yoe2 = 2'd2;
        else if (w_r >= 11'd365)      n_yoe2 = 2'd1;
        else                          n_yoe2 = 2'd0;
        unique case (n_yoe2)
            2'd0: n_doy2 = 9'(w_r);
            2'd1: n_doy2 = 9'(w_r - 11'd365);
            2'd2: n_doy2 = 9'(w_r - 11'd730);
            2'd3: n_doy2 = 9'(w_r - 11'd1095);
        endcase
        n_year2 = 12'd1968 + 12'({w_c, 2'b00}) + 12'(n_yoe2);
        // 1461 is 5 mod 7 and 1968-03-01 fell on a Friday
        n_wsum2 = 11'(w_c) * 11'd5 + w_r + 11'd5 - 11'(w_c_pay.fix);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_doy2  <= n_doy2;
            r_year2 <= n_year2;
            r_wsum2 <= n_wsum2;
            r_pay2  <= w_c_pay.pay;
        end
    end

    // Month by counting passed month starts; weekday quotient by reciprocal
    always_comb begin
        n_mp3 = 4'd0;
        for (int i = 1; i < 12; i++) begin
            n_mp3 = n_mp3 + 4'(r_doy2 >= month_start(4'(i)));
        end
        n_dd3 = 5'(r_doy2 - month_start(n_mp3) + 9'd1);
    end

    assign w_prod3 = 23'(r_wsum2) * 23'd2341;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mp3   <= n_mp3;
            r_dd3   <= n_dd3;
            r_q3    <= 8'(w_prod3 >> 14);
            r_wsum3 <= r_wsum2;
            r_year3 <= r_year2;
            r_pay3  <= r_pay2;
        end
    end

    always_comb begin
        n_date4.weekday = 3'(r_wsum3 - 11'(r_q3) * 11'(DAYS_PER_WEEK));
        n_date4.day     = r_dd3;
        if (r_mp3 < 4'd10) begin
            n_date4.month = r_mp3 + 4'd3;
            n_date4.year  = r_year3;
        end else begin
            n_date4.month = r_mp3 - 4'd9;
            n_date4.year  = r_year3 + 12'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_date4 <= n_date4;
            r_pay4  <= r_pay3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= w_c_vld;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
    end

    assign o_vld  = r_vld4;
    assign o_date = r_date4;
    assign o_pay  = r_pay4;
endmodule

[rtl/ntp_reply_to_local_calendar.sv]
// NTP reply summary in, local civil date, time and EU summer flag out.
// Throughput: one beat per cycle while not stalled; every divider is a pipelined reciprocal unit.
// A stalled result register freezes the whole pipe; nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous): clears all valid bits, zone offset returns to +3600 s.
module ntp_reply_to_local_calendar (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ntpcal_stream_if.sink   i_req,
    ntpcal_stream_if.source o_res,
    ntpcal_stream_if.sink   i_cfg
);
    import ntpcal_pkg::*;

    // Payloads that ride alongside the dividers and calendar units
    typedef struct packed {
        logic        acc;
        logic [31:0] t;
    } t_utc_a;

    typedef struct packed {
        logic        acc;
        logic [31:0] t;
        logic        h1;
    } t_utc_b;

    typedef struct packed {
        logic acc;
        logic summer;
    } t_loc_a;

    typedef struct packed {
        logic        acc;
        logic        summer;
        logic [16:0] sod;
    } t_loc_b;

    typedef struct packed {
        logic  acc;
        logic  summer;
        t_date date;
    } t_loc_c;

    typedef struct packed {
        logic       acc;
        logic       summer;
        t_date      date;
        logic [4:0] hour;
    } t_loc_d;

    // Global advance: the pipe moves whenever the result register is free
    // or being drained this cycle.
    logic         w_en;

    t_zone        r_zone;

    // Stage A: filter and Unix time
    logic         n_a_acc;
    logic [31:0]  n_a_t;
    logic         r_a_vld;
    logic [32:0]  r_a_ux;
    t_utc_a       r_a_pay;

    logic         w_u_vld;
    logic [15:0]  w_u_q;
    logic [16:0]  w_u_sod;
    t_utc_a       w_u_pay;

    logic         w_cu_vld;
    t_date        w_cu_date;
    t_utc_b       w_cu_pay;

    // Stage F: summer decision
    logic [5:0]   w_f_sum;
    logic [2:0]   w_f_wd31;
    logic [4:0]   w_f_last;
    logic         w_f_after;
    logic         n_f_summer;
    logic         r_f_vld;
    logic         r_f_acc;
    logic         r_f_summer;
    logic [31:0]  r_f_t;

    // Stage G: local seconds
    logic [32:0]  w_g_zone;
    logic         r_g_vld;
    logic [32:0]  r_g_ux;
    t_loc_a       r_g_pay;

    logic         w_l_vld;
    logic [15:0]  w_l_q;
    logic [16:0]  w_l_sod;
    t_loc_a       w_l_pay;

    logic         w_cl_vld;
    t_date        w_cl_date;
    t_loc_b       w_cl_pay;

    logic         w_h_vld;
    logic [4:0]   w_h_q;
    logic [11:0]  w_h_rem;
    t_loc_c       w_h_pay;

    logic         w_m_vld;
    logic [5:0]   w_m_q;
    logic [5:0]   w_m_rem;
    t_loc_d       w_m_pay;

    t_res         n_out;
    logic         r_out_vld;
    t_res         r_out;

    assign w_en        = !r_out_vld || o_res.ready;
    assign i_req.ready = w_en;
    assign i_cfg.ready = 1'b1;

    // Zone offset register; the user must keep it written only while the pipe is empty, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= ZONE_RESET;
        end else if (i_cfg.valid) begin
            r_zone <= t_zone'(i_cfg.data);
        end
    end

    // Stage A: accept check, then Unix seconds. Carry one extra day in the
    // dividend (ux) so the UTC and local paths share the same day base.
    assign n_a_acc = (i_req.data.source_port == PORT_NTP)
                  && (i_req.data.packet_length >= LEN_MIN)
                  && (i_req.data.first_byte[2:0] == MODE_SERVER)
                  && (i_req.data.stratum >= STRATUM_MIN)
                  && (i_req.data.stratum <= STRATUM_MAX);
    assign n_a_t   = i_req.data.transmit_seconds - UNIX_DELTA;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_ux  <= 33'(n_a_t) + SEC_PER_DAY;
            r_a_pay <= '{acc: n_a_acc, t: n_a_t};
        end
    end

    // UTC days and second of day
    ntpcal_cdiv #(
        .XW(33), .D(675), .SH(7), .QW(16), .t_pay(t_utc_a)
    ) u_utc_day (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_a_vld),
        .i_x    (r_a_ux),
        .i_pay  (r_a_pay),
        .o_vld  (w_u_vld),
        .o_q    (w_u_q),
        .o_r    (w_u_sod),
        .o_pay  (w_u_pay)
    );

    // UTC calendar; only "hour >= 1" is needed from the time of day
    ntpcal_civil #(
        .t_pay(t_utc_b)
    ) u_utc_civil (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_u_vld),
        .i_days (w_u_q),
        .i_pay  ('{acc: w_u_pay.acc, t: w_u_pay.t,
                   h1: (w_u_sod >= 17'(SEC_PER_HOUR))}),
        .o_vld  (w_cu_vld),
        .o_date (w_cu_date),
        .o_pay  (w_cu_pay)
    );

    // Stage F: EU summer time. In March and October find the last Sunday
    // from the weekday of the 31st; the switch happens at 01:00 UTC.
    always_comb begin
        w_f_sum = 6'(DAYS_LONG_MON - w_cu_date.day) + 6'(w_cu_date.weekday);
        priority if (w_f_sum >= 6'd35) w_f_wd31 = 3'(w_f_sum - 6'd35);
        else if (w_f_sum >= 6'd28)     w_f_wd31 = 3'(w_f_sum - 6'd28);
        else if (w_f_sum >= 6'd21)     w_f_wd31 = 3'(w_f_sum - 6'd21);
        else if (w_f_sum >= 6'd14)     w_f_wd31 = 3'(w_f_sum - 6'd14);
        else if (w_f_sum >= 6'd7)      w_f_wd31 = 3'(w_f_sum - 6'd7);
        else                           w_f_wd31 = 3'(w_f_sum);
        w_f_last  = DAYS_LONG_MON - 5'(w_f_wd31);
        w_f_after = (w_cu_date.day > w_f_last)
                 || ((w_cu_date.day == w_f_last) && w_cu_pay.h1);
        priority if ((w_cu_date.month > MONTH_MAR) && (w_cu_date.month < MONTH_OCT)) begin
            n_f_summer = 1'b1;
        end else if (w_cu_date.month == MONTH_MAR) begin
            n_f_summer = w_f_after;
        end else if (w_cu_date.month == MONTH_OCT) begin
            n_f_summer = !w_f_after;
        end else begin
            n_f_summer = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_acc    <= w_cu_pay.acc;
            r_f_t      <= w_cu_pay.t;
            r_f_summer <= n_f_summer;
        end
    end

    // Stage G: local seconds plus one day of bias; any 17-bit offset keeps
    // the sum positive and below 2^33.
    assign w_g_zone = {{16{r_zone[16]}}, r_zone};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_ux  <= 33'(r_f_t) + w_g_zone
                     + (r_f_summer ? (SEC_PER_DAY + SEC_PER_HOUR) : SEC_PER_DAY);
            r_g_pay <= '{acc: r_f_acc, summer: r_f_summer};
        end
    end

    ntpcal_cdiv #(
        .XW(33), .D(675), .SH(7), .QW(16), .t_pay(t_loc_a)
    ) u_loc_day (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_g_vld),
        .i_x    (r_g_ux),
        .i_pay  (r_g_pay),
        .o_vld  (w_l_vld),
        .o_q    (w_l_q),
        .o_r    (w_l_sod),
        .o_pay  (w_l_pay)
    );

    ntpcal_civil #(
        .t_pay(t_loc_b)
    ) u_loc_civil (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_l_vld),
        .i_days (w_l_q),
        .i_pay  ('{acc: w_l_pay.acc, summer: w_l_pay.summer, sod: w_l_sod}),
        .o_vld  (w_cl_vld),
        .o_date (w_cl_date),
        .o_pay  (w_cl_pay)
    );

    // Split second of day into hour, then minute and second
    ntpcal_cdiv #(
        .XW(17), .D(225), .SH(4), .QW(5), .t_pay(t_loc_c)
    ) u_hour (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_cl_vld),
        .i_x    (w_cl_pay.sod),
        .i_pay  ('{acc: w_cl_pay.acc, summer: w_cl_pay.summer, date: w_cl_date}),
        .o_vld  (w_h_vld),
        .o_q    (w_h_q),
        .o_r    (w_h_rem),
        .o_pay  (w_h_pay)
    );

    ntpcal_cdiv #(
        .XW(12), .D(15), .SH(2), .QW(6), .t_pay(t_loc_d)
    ) u_minute (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_h_vld),
        .i_x    (w_h_rem),
        .i_pay  ('{acc: w_h_pay.acc, summer: w_h_pay.summer,
                   date: w_h_pay.date, hour: w_h_q}),
        .o_vld  (w_m_vld),
        .o_q    (w_m_q),
        .o_r    (w_m_rem),
        .o_pay  (w_m_pay)
    );

    // Result register: drop every field to zero for a rejected reply
    always_comb begin
        n_out = '0;
        if (w_m_pay.acc) begin
            n_out.time_valid  = 1'b1;
            n_out.year        = w_m_pay.date.year;
            n_out.month       = w_m_pay.date.month;
            n_out.day         = w_m_pay.date.day;
            n_out.weekday     = w_m_pay.date.weekday;
            n_out.hour        = w_m_pay.hour;
            n_out.minute      = w_m_q;
            n_out.second      = w_m_rem;
            n_out.summer_time = w_m_pay.summer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_g_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld   <= i_req.valid;
            r_f_vld   <= w_cu_vld;
            r_g_vld   <= r_f_vld;
            r_out_vld <= w_m_vld;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;
endmodule

[rtl/ntpcal_check.sv]
module ntpcal_check (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input ntpcal_pkg::t_res i_res_data
);
    import ntpcal_pkg::*;

    // A waiting result beat holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data))
        else $error("result beat changed while stalled");

    // With the result register empty the pipe must take a request beat
    a_req_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid |-> i_req_ready)
        else $error("request stalled with empty result register");

    // Rejected reply gives an all-zero date, time and summer flag
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_data.time_valid |->
            i_res_data.year == 12'd0 && i_res_data.month == 4'd0
            && i_res_data.day == 5'd0 && i_res_data.weekday == 3'd0
            && i_res_data.hour == 5'd0 && i_res_data.minute == 6'd0
            && i_res_data.second == 6'd0 && !i_res_data.summer_time)
        else $error("rejected reply with nonzero fields");

    // Accepted reply lies in the calendar
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_data.time_valid |->
            i_res_data.year >= 12'd1969 && i_res_data.year <= 12'd2106
            && i_res_data.month >= 4'd1 && i_res_data.month <= 4'd12
            && i_res_data.day >= 5'd1 && i_res_data.day <= 5'd31
            && i_res_data.weekday <= 3'd6 && i_res_data.hour <= 5'd23
            && i_res_data.minute <= 6'd59 && i_res_data.second <= 6'd59)
        else $error("date or time out of range");

    // Summer time lands only between March and October local
    a_summer_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_data.summer_time |->
            i_res_data.month >= MONTH_MAR && i_res_data.month <= MONTH_OCT)
        else $error("summer flag outside March to October");
endmodule

bind ntp_reply_to_local_calendar ntpcal_check u_ntpcal_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_req_valid(i_req.valid),
    .i_req_ready(i_req.ready),
    .i_res_valid(o_res.valid),
    .i_res_ready(o_res.ready),
    .i_res_data (o_res.data)
);
